/* hdl/hsvc_pkg.sv */
// ----------------------------------------------------------------------------
// hsvc_pkg
// Types, widths and constants shared by the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsvc_pkg;

	localparam int HUE_W   = 9;
	localparam int PCT_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int SV_W    = 14;  // s*v, up to 127*127
	localparam int WGT_W   = 6;   // 60 - |t - 60|, 0..60
	localparam int NUM_W   = 20;  // channel numerator over 600000
	localparam int SUM_W   = 24;  // 17*N + 20000
	localparam int A_SHIFT = 6;   // 40000 = 64 * 625
	localparam int A_W     = SUM_W - A_SHIFT;
	localparam int RECIP_W = 19;
	localparam int PROD_W  = A_W + RECIP_W;
	localparam int RECIP_SHIFT = 28;

	localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [HUE_W-1:0] DEG_60  = 9'd60;
	localparam logic [HUE_W-1:0] DEG_120 = 9'd120;
	localparam logic [HUE_W-1:0] DEG_180 = 9'd180;
	localparam logic [HUE_W-1:0] DEG_240 = 9'd240;
	localparam logic [HUE_W-1:0] DEG_300 = 9'd300;

	localparam logic [NUM_W-1:0] CHROMA_SCALE = 20'd60;
	localparam logic [NUM_W-1:0] VALUE_SCALE  = 20'd6000;

	// 255/600000 = 17/40000; round half up adds 20000 before the divide
	localparam logic [SUM_W-1:0] BYTE_MUL   = 24'd17;
	localparam logic [SUM_W-1:0] ROUND_ADD  = 24'd20000;
	// ceil(2^28 / 625), exact for quotients of an 18-bit dividend
	localparam logic [RECIP_W-1:0] RECIP_625 = 19'd429497;

	localparam int LANES = 3;

	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	typedef struct packed {
		logic valid;
		logic ok;
	} ctl_t;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [BYTE_W-1:0] byte_t;

endpackage

/* hdl/hsvc_decode.sv */
// ----------------------------------------------------------------------------
// hsvc_decode
// First stage: range check, sector decode, hue weight and the s*v product.
// ----------------------------------------------------------------------------
module hsvc_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hsvc_pkg::HUE_W-1:0] hue,
	input  logic [hsvc_pkg::PCT_W-1:0] saturation,
	input  logic [hsvc_pkg::PCT_W-1:0] brightness,
	output hsvc_pkg::ctl_t             ctl_s1,
	output hsvc_pkg::sector_t          sector_s1,
	output logic [hsvc_pkg::SV_W-1:0]  sv_s1,
	output logic [hsvc_pkg::WGT_W-1:0] wgt_s1,
	output logic [hsvc_pkg::PCT_W-1:0] val_s1
);
	import hsvc_pkg::*;

	logic            ok_d;
	logic [HUE_W-1:0] t_d;
	logic [HUE_W-1:0] wgt_d;
	sector_t         sector_d;

	always_comb begin
		ok_d = (hue <= HUE_MAX) && (saturation <= PCT_MAX) && (brightness <= PCT_MAX);

		// hue mod 120 by compare and subtract, exact for hue below 360
		if (hue < DEG_120) begin
			t_d = hue;
		end else if (hue < DEG_240) begin
			t_d = hue - DEG_120;
		end else begin
			t_d = hue - DEG_240;
		end

		// 60 - |t - 60|
		if (t_d >= DEG_60) begin
			wgt_d = DEG_120 - t_d;
		end else begin
			wgt_d = t_d;
		end

		if (hue < DEG_60) begin
			sector_d = SEC_RED_YEL;
		end else if (hue < DEG_120) begin
			sector_d = SEC_YEL_GRN;
		end else if (hue < DEG_180) begin
			sector_d = SEC_GRN_CYN;
		end else if (hue < DEG_240) begin
			sector_d = SEC_CYN_BLU;
		end else if (hue < DEG_300) begin
			sector_d = SEC_BLU_MAG;
		end else begin
			sector_d = SEC_MAG_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.ok    <= ok_d;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= sector_d;
		sv_s1     <= SV_W'(saturation) * SV_W'(brightness);
		wgt_s1    <= wgt_d[WGT_W-1:0];
		val_s1    <= brightness;
	end

endmodule

/* hdl/hsvc_chroma.sv */
// ----------------------------------------------------------------------------
// hsvc_chroma
// Stages two and three: chroma, X and m, then per-channel numerators.
// ----------------------------------------------------------------------------
module hsvc_chroma (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hsvc_pkg::ctl_t             ctl_s1,
	input  hsvc_pkg::sector_t          sector_s1,
	input  logic [hsvc_pkg::SV_W-1:0]  sv_s1,
	input  logic [hsvc_pkg::WGT_W-1:0] wgt_s1,
	input  logic [hsvc_pkg::PCT_W-1:0] val_s1,
	output hsvc_pkg::ctl_t             ctl_s3,
	output hsvc_pkg::num_t [hsvc_pkg::LANES-1:0] num_s3
);
	import hsvc_pkg::*;

	ctl_t    ctl_s2;
	sector_t sector_s2;
	num_t    c_s2;
	num_t    x_s2;
	num_t    m_s2;
	num_t    c_d;
	num_t    r_d;
	num_t    g_d;
	num_t    b_d;

	assign c_d = NUM_W'(sv_s1) * CHROMA_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		c_s2      <= c_d;
		x_s2      <= NUM_W'(sv_s1) * NUM_W'(wgt_s1);
		m_s2      <= NUM_W'(val_s1) * VALUE_SCALE - c_d;
	end

	always_comb begin
		unique case (sector_s2)
			SEC_RED_YEL: begin r_d = c_s2; g_d = x_s2; b_d = '0;   end
			SEC_YEL_GRN: begin r_d = x_s2; g_d = c_s2; b_d = '0;   end
			SEC_GRN_CYN: begin r_d = '0;   g_d = c_s2; b_d = x_s2; end
			SEC_CYN_BLU: begin r_d = '0;   g_d = x_s2; b_d = c_s2; end
			SEC_BLU_MAG: begin r_d = x_s2; g_d = '0;   b_d = c_s2; end
			SEC_MAG_RED: begin r_d = c_s2; g_d = '0;   b_d = x_s2; end
			default:     begin r_d = '0;   g_d = '0;   b_d = '0;   end
		endcase
	end

	// out-of-range beats are forced to zero here, which scales to black
	always_ff @(posedge clk) begin
		if (ctl_s2.ok) begin
			num_s3[0] <= r_d + m_s2;
			num_s3[1] <= g_d + m_s2;
			num_s3[2] <= b_d + m_s2;
		end else begin
			num_s3 <= '0;
		end
	end

endmodule

/* hdl/hsvc_scale.sv */
// ----------------------------------------------------------------------------
// hsvc_scale
// Stages four and five: round(255*N/600000) per channel by reciprocal multiply.
// ----------------------------------------------------------------------------
module hsvc_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hsvc_pkg::ctl_t                       ctl_s3,
	input  hsvc_pkg::num_t [hsvc_pkg::LANES-1:0] num_s3,
	output hsvc_pkg::ctl_t                       ctl_s5,
	output hsvc_pkg::byte_t [hsvc_pkg::LANES-1:0] byte_s5
);
	import hsvc_pkg::*;

	ctl_t                       ctl_s4;
	logic [LANES-1:0][A_W-1:0]  a_s4;
	logic [LANES-1:0][SUM_W-1:0] sum_d;
	logic [LANES-1:0][PROD_W-1:0] prod_d;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sum_d[i]  = SUM_W'(num_s3[i]) * BYTE_MUL + ROUND_ADD;
			prod_d[i] = PROD_W'(a_s4[i]) * PROD_W'(RECIP_625);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			a_s4[i]    <= sum_d[i][SUM_W-1:A_SHIFT];
			byte_s5[i] <= prod_d[i][RECIP_SHIFT +: BYTE_W];
		end
	end

endmodule

/* hdl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five-stage HSV to 8-bit RGB colour conversion, one beat per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive hue (degrees), saturation and brightness (percent) with
//   start high; the beat is taken on any rising edge where start is high and
//   busy is low. busy is held low, so a beat may be offered on every clock.
//   Result beat: red, green, blue and in_range are shown for one cycle with
//   done high, once the beat has passed through every stage. Results leave in
//   the order the beats came in.
//   A hue over 360 or a saturation or brightness over 100 gives black with
//   in_range low.
//   Throughput is one beat per clock. The stages, in order, are:
//   decode and s*v, chroma products, channel sums, rounding
//   scale, reciprocal divide by 625.
//   Reset clears every stage's valid bit, so no done appears until beats
//   have been taken. There is no output back-pressure: the receiver must take
//   each result in the cycle it is shown.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [hsvc_pkg::HUE_W-1:0]  hue,
	input  logic [hsvc_pkg::PCT_W-1:0]  saturation,
	input  logic [hsvc_pkg::PCT_W-1:0]  brightness,
	output logic                        done,
	output logic [hsvc_pkg::BYTE_W-1:0] red,
	output logic [hsvc_pkg::BYTE_W-1:0] green,
	output logic [hsvc_pkg::BYTE_W-1:0] blue,
	output logic                        in_range
);
	import hsvc_pkg::*;

	ctl_t               ctl_s1;
	sector_t            sector_s1;
	logic [SV_W-1:0]    sv_s1;
	logic [WGT_W-1:0]   wgt_s1;
	logic [PCT_W-1:0]   val_s1;
	ctl_t               ctl_s3;
	num_t [LANES-1:0]   num_s3;
	ctl_t               ctl_s5;
	byte_t [LANES-1:0]  byte_s5;

	hsvc_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.ctl_s1     (ctl_s1),
		.sector_s1  (sector_s1),
		.sv_s1      (sv_s1),
		.wgt_s1     (wgt_s1),
		.val_s1     (val_s1)
	);

	hsvc_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.sector_s1 (sector_s1),
		.sv_s1     (sv_s1),
		.wgt_s1    (wgt_s1),
		.val_s1    (val_s1),
		.ctl_s3    (ctl_s3),
		.num_s3    (num_s3)
	);

	hsvc_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s3  (ctl_s3),
		.num_s3  (num_s3),
		.ctl_s5  (ctl_s5),
		.byte_s5 (byte_s5)
	);

	assign busy     = 1'b0;
	assign done     = ctl_s5.valid;
	assign in_range = ctl_s5.ok;
	assign red      = byte_s5[0];
	assign green    = byte_s5[1];
	assign blue     = byte_s5[2];

endmodule

/* hdl/hsvc_checker.sv */
// ----------------------------------------------------------------------------
// hsvc_checker
// Port-level checks on the converter: latency, range flag, black and grey colours.
// ----------------------------------------------------------------------------
module hsvc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [hsvc_pkg::HUE_W-1:0]  hue,
	input logic [hsvc_pkg::PCT_W-1:0]  saturation,
	input logic [hsvc_pkg::PCT_W-1:0]  brightness,
	input logic                        done,
	input logic [hsvc_pkg::BYTE_W-1:0] red,
	input logic [hsvc_pkg::BYTE_W-1:0] green,
	input logic [hsvc_pkg::BYTE_W-1:0] blue,
	input logic                        in_range
);
	import hsvc_pkg::*;

	// every taken beat comes out as a done beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result beat missing after accepted input");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##5 !done)
		else $error("result beat without an input beat");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_range) |-> (red == '0 && green == '0 && blue == '0))
		else $error("out-of-range beat not black");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (hue > HUE_MAX || saturation > PCT_MAX ||
		brightness > PCT_MAX)) |-> ##5 (done && !in_range))
		else $error("range flag wrong for out-of-range input");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && saturation == '0 && hue <= HUE_MAX &&
		brightness <= PCT_MAX) |-> ##5 (in_range && red == green && green == blue))
		else $error("zero saturation did not give grey");

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.hue        (hue),
	.saturation (saturation),
	.brightness (brightness),
	.done       (done),
	.red        (red),
	.green      (green),
	.blue       (blue),
	.in_range   (in_range)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the HSV to RGB converter beat by beat: every taken input beat is
// converted by an exact integer colour model, and each done beat is compared
// in order against the oldest predicted colour, across in- and out-of-range
// inputs and random idle gaps.
// ----------------------------------------------------------------------------
module testbench;

	import hsvc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          SETTLE      = 10;
	localparam int          RAND_BEATS  = 1850;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] bri;
		int               gap;
		bit               drain;
	} hsv_beat_t;

	typedef struct {
		byte_t red;
		byte_t green;
		byte_t blue;
		logic  in_range;
	} colour_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic [HUE_W-1:0]     hue        = '0;
	logic [PCT_W-1:0]     saturation = '0;
	logic [PCT_W-1:0]     brightness = '0;
	logic                 busy;
	logic                 done;
	logic [BYTE_W-1:0]    red;
	logic [BYTE_W-1:0]    green;
	logic [BYTE_W-1:0]    blue;
	logic                 in_range;

	hsv_beat_t   pending_beats[$];
	colour_t     colours_due[$];
	hsv_beat_t   cur;
	bit          have_cur      = 1'b0;
	logic        beat_taken    = 1'b0;
	int          beats_queued  = 0;
	int          beats_taken   = 0;
	int          mismatch_count = 0;
	int unsigned cycle_count   = 0;

	hsv_to_rgb_converter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.in_range   (in_range)
	);

	initial forever #5 clk = ~clk;

	// --------------------------------------------------------------------
	// Colour model: channel numerators over 600000, rounded half up
	// --------------------------------------------------------------------
	function automatic byte_t numer_to_byte(longint unsigned numer);
		return byte_t'((255 * numer + 300000) / 600000);
	endfunction

	function automatic colour_t colour_of(logic [HUE_W-1:0] h, logic [PCT_W-1:0] s,
	                                      logic [PCT_W-1:0] v);
		longint unsigned hh, ss, vv, t, hue_dist, chroma, side, base, r, g, b;
		sector_t         sec;
		colour_t         c;
		c = '{default: '0};
		if (h > HUE_MAX || s > PCT_MAX || v > PCT_MAX)
			return c;
		hh       = h;
		ss       = s;
		vv       = v;
		t        = hh % 120;
		hue_dist = (t >= 60) ? t - 60 : 60 - t;
		chroma   = ss * vv * 60;
		side     = ss * vv * (60 - hue_dist);
		base     = vv * 6000 - chroma;
		if (h < DEG_60)       sec = SEC_RED_YEL;
		else if (h < DEG_120) sec = SEC_YEL_GRN;
		else if (h < DEG_180) sec = SEC_GRN_CYN;
		else if (h < DEG_240) sec = SEC_CYN_BLU;
		else if (h < DEG_300) sec = SEC_BLU_MAG;
		else                  sec = SEC_MAG_RED;
		case (sec)
			SEC_RED_YEL: begin r = chroma; g = side;   b = 0;      end
			SEC_YEL_GRN: begin r = side;   g = chroma; b = 0;      end
			SEC_GRN_CYN: begin r = 0;      g = chroma; b = side;   end
			SEC_CYN_BLU: begin r = 0;      g = side;   b = chroma; end
			SEC_BLU_MAG: begin r = side;   g = 0;      b = chroma; end
			default:     begin r = chroma; g = 0;      b = side;   end
		endcase
		c.red      = numer_to_byte(r + base);
		c.green    = numer_to_byte(g + base);
		c.blue     = numer_to_byte(b + base);
		c.in_range = 1'b1;
		return c;
	endfunction

	function automatic void note_mismatch(string field, int exp_val, int got_val);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] error on %s: expected %0d, got %0d", $realtime, field,
			         exp_val, got_val);
	endfunction

	// --------------------------------------------------------------------
	// Stimulus building
	// --------------------------------------------------------------------
	function automatic int idle_gap(bit burst);
		int roll;
		if (burst)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_beat(int h, int s, int v, int gap, bit drain);
		hsv_beat_t b;
		b.hue   = h[HUE_W-1:0];
		b.sat   = s[PCT_W-1:0];
		b.bri   = v[PCT_W-1:0];
		b.gap   = gap;
		b.drain = drain;
		pending_beats.push_back(b);
		beats_queued++;
	endfunction

	initial begin
		bit burst;
		int h, s, v;

		// primaries, secondaries, sector edges and the 360 wrap
		add_beat(0,   100, 100, 0, 0);
		add_beat(60,  100, 100, 0, 0);
		add_beat(120, 100, 100, 0, 0);
		add_beat(180, 100, 100, 0, 0);
		add_beat(240, 100, 100, 0, 0);
		add_beat(300, 100, 100, 0, 0);
		add_beat(360, 100, 100, 0, 0);
		add_beat(359, 100, 100, 1, 0);
		add_beat(59,  100, 100, 0, 0);
		add_beat(119, 100, 100, 0, 0);
		add_beat(299, 100, 100, 2, 0);
		add_beat(0,   0,   0,   0, 0);
		add_beat(0,   0,   100, 0, 0);
		add_beat(30,  50,  50,  0, 0);
		add_beat(90,  1,   1,   0, 0);
		add_beat(210, 33,  67,  0, 0);
		add_beat(100, 127, 0,   0, 0);
		// out of range on each field, and everything at the top
		add_beat(361, 50,  50,  0, 0);
		add_beat(0,   101, 50,  0, 0);
		add_beat(0,   50,  101, 3, 0);
		add_beat(511, 127, 127, 0, 0);
		add_beat(511, 0,   0,   0, 0);
		add_beat(256, 64,  64,  0, 0);
		add_beat(360, 100, 0,   0, 1);

		for (int i = 0; i < RAND_BEATS; i++) begin
			burst = ((i / 150) % 3) == 1;
			if ($urandom_range(0, 99) < 75) begin
				h = $urandom_range(0, 360);
				s = $urandom_range(0, 100);
				v = $urandom_range(0, 100);
				if ($urandom_range(0, 19) == 0) s = 100;
				if ($urandom_range(0, 19) == 0) v = 100;
			end else begin
				h = $urandom_range(0, 511);
				s = $urandom_range(0, 127);
				v = $urandom_range(0, 127);
			end
			add_beat(h, s, v, idle_gap(burst), (i % 400) == 399);
		end
	end

	// --------------------------------------------------------------------
	// Reset, driver, monitor
	// --------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// beat_taken tells the driver whether the beat it offered went in
	always @(negedge clk) begin
		bit drive;
		drive = 1'b0;
		if (arst_n) begin
			if (start && !beat_taken) begin
				drive = 1'b1;
			end else begin
				if (!have_cur && pending_beats.size() > 0) begin
					cur      = pending_beats.pop_front();
					have_cur = 1'b1;
				end
				if (have_cur) begin
					if (cur.gap > 0) begin
						cur.gap--;
					end else if (!(cur.drain && colours_due.size() != 0)) begin
						drive      = 1'b1;
						have_cur   = 1'b0;
						hue        <= cur.hue;
						saturation <= cur.sat;
						brightness <= cur.bri;
					end
				end
			end
		end
		start <= drive;
	end

	always @(posedge clk or negedge arst_n) begin
		colour_t want;
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			// check before queueing, so a stray done never meets this beat
			if (done) begin
				if (colours_due.size() == 0) begin
					note_mismatch("unexpected result beat", 0, 1);
				end else begin
					want = colours_due.pop_front();
					if (red !== want.red)           note_mismatch("red", want.red, red);
					if (green !== want.green)       note_mismatch("green", want.green, green);
					if (blue !== want.blue)         note_mismatch("blue", want.blue, blue);
					if (in_range !== want.in_range) note_mismatch("in_range", want.in_range,
					                                              in_range);
				end
			end
			beat_taken <= start && !busy;
			if (start && !busy) begin
				colours_due.push_back(colour_of(hue, saturation, brightness));
				beats_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		while (beats_taken < beats_queued || colours_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
